>>> rtl/core/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared widths and register indexes for the lambda accumulator.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PROD_W  = 2 * WORD_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_COEF   = 2'd1,
    CFG_INVRHO = 2'd2
  } cfg_idx_e;

endpackage

>>> rtl/core/pla_mul.sv
// ----------------------------------------------------------------------------
// pla_mul
// Serial shift-add multiplier, one multiplier bit per cycle, early finish.
// ----------------------------------------------------------------------------
module pla_mul
  import pla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic              busy_q, busy_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      a_d    = {{WORD_W{1'b0}}, a_i};
      b_d    = b_i;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[PROD_W-2:0], 1'b0};
        b_d = {1'b0, b_q[WORD_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

endmodule

>>> rtl/core/pla_div.sv
// ----------------------------------------------------------------------------
// pla_div
// Restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module pla_div
  import pla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] num_i,
  input  logic [WORD_W-1:0] den_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] den_q, den_d;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[WORD_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo_d = {quo_q[WORD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

endmodule

>>> rtl/core/pbf_lambda_accumulate.sv
// ----------------------------------------------------------------------------
// pbf_lambda_accumulate
// Density constraint multiplier of one particle, built from its neighbors.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis group, one per neighbor; tlast marks the
// final item of a particle and tuser says whether the item holds a neighbor.
// The final item produces one result on m_axis: lambda in tdata and the close
// pair flag in tuser. Other items produce nothing.
// Items are worked one at a time. A neighbor item runs three squares and a
// 32-step root and, when within the radius, two gradient products and, when
// the gradient is nonzero, per axis a product, a 64-step divide and a square.
// The last item adds the norm, scaling and the final divide. The serial
// multiplier (one multiplier bit per cycle, ends early on short operands) and
// the restoring divider set the latency, which is data dependent.
// s_axis_tready is high only while the sequencer is idle. A finished result sits
// in an output register, so the next item is taken while m_axis stalls; a second
// result waits until the register drains.
// Reset loads the default register values and clears all sums.
// ----------------------------------------------------------------------------
module pbf_lambda_accumulate
  import pla_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // offset_x, offset_y, offset_z, own_density, zero pad
  input  logic [127:0]         s_axis_tdata,
  // has_neighbor
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // lambda_value
  output logic [31:0]          m_axis_tdata,
  // close_pair
  output logic                 m_axis_tuser,
  input  logic                 cfg_wen_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  localparam int unsigned EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam logic [31:0] EPS     = (EPS_RAW == 0) ? 32'd1 : 32'(EPS_RAW);
  localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< 47) - 66'sd1;
  localparam logic signed [65:0] SUM_MIN = -(66'sd1 <<< 47);
  localparam logic [31:0] COEF_RST = 32'(-32'sd938734);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_SQ   = 14'b00000000000010,
    ST_ROOT = 14'b00000000000100,
    ST_TT   = 14'b00000000001000,
    ST_CG   = 14'b00000000010000,
    ST_GX   = 14'b00000000100000,
    ST_DV   = 14'b00000001000000,
    ST_CC   = 14'b00000010000000,
    ST_FIN  = 14'b00000100000000,
    ST_GG   = 14'b00001000000000,
    ST_S1   = 14'b00010000000000,
    ST_S2   = 14'b00100000000000,
    ST_RA   = 14'b01000000000000,
    ST_EMIT = 14'b10000000000000
  } state_e;

  function automatic logic [WORD_W-1:0] add_sat(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? '1 : s[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mul_sat(logic [PROD_W-1:0] p);
    return (|p[PROD_W-1:FRAC_BITS+WORD_W]) ? '1 : p[FRAC_BITS+WORD_W-1:FRAC_BITS];
  endfunction

  function automatic logic [47:0] sum_add(logic [47:0] s, logic [WORD_W-1:0] d, logic neg);
    logic signed [65:0] se;
    logic signed [65:0] de;
    logic signed [65:0] r;
    se = 66'(signed'(s));
    de = signed'({2'b00, d});
    r  = neg ? se - de : se + de;
    if (r > SUM_MAX) begin
      r = SUM_MAX;
    end else if (r < SUM_MIN) begin
      r = SUM_MIN;
    end
    return r[47:0];
  endfunction

  function automatic logic [47:0] abs48(logic [47:0] s);
    return s[47] ? 48'(-s) : s;
  endfunction

  state_e            state_q, state_d;
  logic [1:0]        idx_q, idx_d, idx_nx;
  logic [2:0][31:0]  mag_q, mag_d, in_mag;
  logic [2:0]        neg_q, neg_d;
  logic [30:0]       dens_q, dens_d;
  logic              last_q, last_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] sqv_q, sqv_d;
  logic [33:0]       rem_q, rem_d;
  logic [31:0]       root_q, root_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [31:0]       r_q, r_d;
  logic [30:0]       gm_q, gm_d;
  logic [WORD_W-1:0] cx_q, cx_d;
  logic              cpos_q, cpos_d;
  logic [2:0][47:0]  gs_q, gs_d;
  logic [WORD_W-1:0] ssum_q, ssum_d;
  logic              clamp_q, clamp_d;
  logic [30:0]       h_q;
  logic [31:0]       coef_q;
  logic [30:0]       inv_q;
  logic              mul_go_q, mul_go_d;
  logic [WORD_W-1:0] mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic              div_go_q, div_go_d;
  logic [WORD_W-1:0] div_n_q, div_n_d, div_d_q, div_d_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_lam_q, out_lam_d;
  logic              out_close_q, out_close_d;
  logic              u_div_busy, div_wait_q, div_wait_d;

  logic              mul_done, div_done;
  logic [PROD_W-1:0] mul_prod;
  logic [WORD_W-1:0] div_quo;
  logic [31:0]       coef_mag;
  logic [35:0]       rem_sh, trial;
  logic              root_ge;
  logic [33:0]       rem_nx;
  logic [31:0]       root_nx;
  logic [30:0]       gm_sat;
  logic [WORD_W-1:0] ratio, cmag, gg_acc, sat_q;
  logic              out_free;
  logic [31:0]       lam;
  logic [WORD_W-1:0] lam_sat;

  pla_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pla_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_n_q),
    .den_i   (div_d_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign in_mag[k] = s_axis_tdata[32*k+31] ? 32'(-s_axis_tdata[32*k +: 32])
                                             : s_axis_tdata[32*k +: 32];
  end

  assign idx_nx   = idx_q + 2'd1;
  assign coef_mag = coef_q[31] ? 32'(-coef_q) : coef_q;
  assign rem_sh   = {rem_q, sqv_q[WORD_W-1:WORD_W-2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign root_ge  = rem_sh >= trial;
  assign rem_nx   = root_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
  assign root_nx  = {root_q[30:0], root_ge};
  assign gm_sat   = (|mul_prod[PROD_W-1:FRAC_BITS+31]) ? 31'h7FFF_FFFF
                                                       : mul_prod[FRAC_BITS+30:FRAC_BITS];
  assign ratio    = mul_prod[WORD_W-1:0] >> FRAC_BITS;
  assign cmag     = (ratio > ONE) ? ratio - ONE : ONE - ratio;
  assign gg_acc   = add_sat(acc_q, mul_sat(mul_prod));
  assign sat_q    = mul_sat(mul_prod);
  assign out_free = !out_valid_q || m_axis_tready;
  assign lam_sat  = cpos_q ? ((div_quo > 64'h8000_0000) ? 64'h8000_0000 : div_quo)
                           : ((div_quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : div_quo);
  assign lam      = cpos_q ? 32'(-lam_sat[31:0]) : lam_sat[31:0];

  // quotient is valid once the divider has finished and gone quiet
  assign u_div_busy = div_wait_q;
  assign div_wait_d = div_go_q ? 1'b1 : (div_done ? 1'b0 : div_wait_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_lam_q;
  assign m_axis_tuser  = out_close_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    dens_d      = dens_q;
    last_d      = last_q;
    acc_d       = acc_q;
    sqv_d       = sqv_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    r_d         = r_q;
    gm_d        = gm_q;
    cx_d        = cx_q;
    cpos_d      = cpos_q;
    gs_d        = gs_q;
    ssum_d      = ssum_q;
    clamp_d     = clamp_q;
    mul_go_d    = 1'b0;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    div_go_d    = 1'b0;
    div_n_d     = div_n_q;
    div_d_d     = div_d_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_lam_d   = out_lam_q;
    out_close_d = out_close_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mag_d  = in_mag;
          neg_d  = {s_axis_tdata[95], s_axis_tdata[63], s_axis_tdata[31]};
          dens_d = s_axis_tdata[126:96];
          last_d = s_axis_tlast;
          idx_d  = 2'd0;
          if (s_axis_tuser) begin
            acc_d    = '0;
            mul_go_d = 1'b1;
            mul_a_d  = {32'b0, in_mag[0]};
            mul_b_d  = {32'b0, in_mag[0]};
            state_d  = ST_SQ;
          end else if (s_axis_tlast) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          acc_d = acc_q + mul_prod[WORD_W-1:0];
          if (idx_q != 2'd2) begin
            idx_d    = idx_nx;
            mul_go_d = 1'b1;
            mul_a_d  = {32'b0, mag_q[idx_nx]};
            mul_b_d  = {32'b0, mag_q[idx_nx]};
          end else begin
            sqv_d   = acc_q + mul_prod[WORD_W-1:0];
            rem_d   = '0;
            root_d  = '0;
            cnt_d   = '0;
            state_d = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        rem_d  = rem_nx;
        root_d = root_nx;
        sqv_d  = {sqv_q[WORD_W-3:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          r_d     = (root_nx < EPS) ? EPS : root_nx;
          clamp_d = clamp_q | (root_nx < EPS);
          if ({1'b0, h_q} >= root_nx) begin
            mul_go_d = 1'b1;
            mul_a_d  = {33'b0, 31'({1'b0, h_q} - root_nx)};
            mul_b_d  = {33'b0, 31'({1'b0, h_q} - root_nx)};
            state_d  = ST_TT;
          end else begin
            state_d = last_q ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_TT: begin
        if (mul_done) begin
          mul_go_d = 1'b1;
          mul_a_d  = {32'b0, coef_mag};
          mul_b_d  = mul_prod[WORD_W-1:0] >> FRAC_BITS;
          state_d  = ST_CG;
        end
      end
      ST_CG: begin
        if (mul_done) begin
          gm_d  = gm_sat;
          idx_d = 2'd0;
          if (gm_sat == '0) begin
            state_d = last_q ? ST_FIN : ST_IDLE;
          end else begin
            mul_go_d = 1'b1;
            mul_a_d  = {33'b0, gm_sat};
            mul_b_d  = {32'b0, mag_q[0]};
            state_d  = ST_GX;
          end
        end
      end
      ST_GX: begin
        if (mul_done) begin
          div_go_d = 1'b1;
          div_n_d  = mul_prod[WORD_W-1:0];
          div_d_d  = {32'b0, r_q};
          state_d  = ST_DV;
        end
      end
      ST_DV: begin
        if (div_done) begin
          cx_d     = div_quo;
          mul_go_d = 1'b1;
          mul_a_d  = div_quo;
          mul_b_d  = div_quo;
          state_d  = ST_CC;
        end
      end
      ST_CC: begin
        if (mul_done) begin
          ssum_d       = add_sat(ssum_q, mul_prod[WORD_W-1:0] >> FRAC_BITS);
          gs_d[idx_q]  = sum_add(gs_q[idx_q], cx_q, coef_q[31] ^ neg_q[idx_q]);
          if (idx_q != 2'd2) begin
            idx_d    = idx_nx;
            mul_go_d = 1'b1;
            mul_a_d  = {33'b0, gm_q};
            mul_b_d  = {32'b0, mag_q[idx_nx]};
            state_d  = ST_GX;
          end else begin
            state_d = last_q ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        acc_d    = ssum_q;
        idx_d    = 2'd0;
        mul_go_d = 1'b1;
        mul_a_d  = {16'b0, abs48(gs_q[0])};
        mul_b_d  = {16'b0, abs48(gs_q[0])};
        state_d  = ST_GG;
      end
      ST_GG: begin
        if (mul_done) begin
          acc_d    = gg_acc;
          mul_go_d = 1'b1;
          if (idx_q != 2'd2) begin
            idx_d   = idx_nx;
            mul_a_d = {16'b0, abs48(gs_q[idx_nx])};
            mul_b_d = {16'b0, abs48(gs_q[idx_nx])};
          end else begin
            mul_a_d = gg_acc;
            mul_b_d = {33'b0, inv_q};
            state_d = ST_S1;
          end
        end
      end
      ST_S1: begin
        if (mul_done) begin
          acc_d    = sat_q;
          mul_go_d = 1'b1;
          mul_a_d  = sat_q;
          mul_b_d  = {33'b0, inv_q};
          state_d  = ST_S2;
        end
      end
      ST_S2: begin
        if (mul_done) begin
          acc_d    = sat_q;
          mul_go_d = 1'b1;
          mul_a_d  = {33'b0, dens_q};
          mul_b_d  = {33'b0, inv_q};
          state_d  = ST_RA;
        end
      end
      ST_RA: begin
        if (mul_done) begin
          cpos_d   = ratio > ONE;
          div_go_d = 1'b1;
          div_n_d  = cmag << FRAC_BITS;
          div_d_d  = add_sat(acc_q, ONE);
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (div_done || (!div_go_q && !u_div_busy)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_lam_d   = lam;
            out_close_d = clamp_q;
            gs_d        = '0;
            ssum_d      = '0;
            clamp_d     = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gs_q        <= '0;
      ssum_q      <= '0;
      clamp_q     <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      div_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= 31'd65536;
      coef_q      <= COEF_RST;
      inv_q       <= 31'd65536;
    end else begin
      state_q     <= state_d;
      gs_q        <= gs_d;
      ssum_q      <= ssum_d;
      clamp_q     <= clamp_d;
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      div_wait_q  <= div_wait_d;
      out_valid_q <= out_valid_d;
      if (cfg_wen_i) begin
        case (cfg_idx_i)
          CFG_RADIUS: h_q    <= cfg_wdata_i[30:0];
          CFG_COEF:   coef_q <= cfg_wdata_i;
          CFG_INVRHO: inv_q  <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    dens_q      <= dens_d;
    last_q      <= last_d;
    acc_q       <= acc_d;
    sqv_q       <= sqv_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    cnt_q       <= cnt_d;
    r_q         <= r_d;
    gm_q        <= gm_d;
    cx_q        <= cx_d;
    cpos_q      <= cpos_d;
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    div_n_q     <= div_n_d;
    div_d_q     <= div_d_d;
    out_lam_q   <= out_lam_d;
    out_close_q <= out_close_d;
  end

  a_emit_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |=> (ssum_q == '0 && !clamp_q))
    else $error("sums not cleared after result");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("root remainder out of bound");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> (div_d_q != '0))
    else $error("divide by zero started");

endmodule

>>> tb/pbf_lambda_accumulate_tb.sv
// ----------------------------------------------------------------------------
// pbf_lambda_accumulate_tb
// Self-checking bench for the lambda accumulator: directed and random items
// are driven, two random phases under back-pressure, and every lambda result
// is compared against a bit-accurate fixed-point predictor in a scoreboard.
// ----------------------------------------------------------------------------
module pbf_lambda_accumulate_tb
  import pla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FB;
  localparam logic [63:0] U64_MAX = '1;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh8000_0000_0000;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [31:0] lambda_value;
    logic        close_pair;
  } lambda_res_t;

  int unsigned n_errors;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> FB;
    return (p[127:64] != 0) ? U64_MAX : p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag32(logic [31:0] v, output logic neg);
    neg = v[31];
    return neg ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
  endfunction

  function automatic longint grad_add(longint s, logic [63:0] m, logic neg);
    s = neg ? s - longint'(m) : s + longint'(m);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    return s;
  endfunction

  class lambda_scoreboard;
    logic [30:0] radius = 31'd65536;
    logic [31:0] coeff = -32'sd938734;
    logic [30:0] inv_rho = 31'd65536;
    longint grad_x, grad_y, grad_z;
    logic [63:0] sq_sum = '0;
    logic clamped = 1'b0;
    lambda_res_t pending[$];
    int unsigned n_results;

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_RADIUS: radius = val[30:0];
        CFG_COEF:   coeff = val;
        CFG_INVRHO: inv_rho = val[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [31:0] ox, oy, oz, logic [30:0] dens,
                            logic has_nb, logic last);
      logic nx, ny, nz, cneg;
      logic [63:0] mx, my, mz, r, cm, gm, t, cx, cy, cz, eps;
      logic [63:0] s, ratio, cmag, den, qv;
      logic cpos;
      lambda_res_t res;
      eps = (ONE_Q + 5000) / 10000;
      if (eps == 0) eps = 1;
      if (has_nb) begin
        mx = mag32(ox, nx);
        my = mag32(oy, ny);
        mz = mag32(oz, nz);
        r = int_root(mx * mx + my * my + mz * mz);
        cm = mag32(coeff, cneg);
        gm = 0;
        if (r <= {33'd0, radius}) begin
          t = {33'd0, radius} - r;
          gm = mul_shift_sat(cm, (t * t) >> FB);
          if (gm > 64'h7FFF_FFFF) gm = 64'h7FFF_FFFF;
        end
        if (r < eps) begin
          r = eps;
          clamped = 1;
        end
        cx = (gm * mx) / r;
        cy = (gm * my) / r;
        cz = (gm * mz) / r;
        grad_x = grad_add(grad_x, cx, cneg != nx);
        grad_y = grad_add(grad_y, cy, cneg != ny);
        grad_z = grad_add(grad_z, cz, cneg != nz);
        sq_sum = add_sat(sq_sum, (cx * cx) >> FB);
        sq_sum = add_sat(sq_sum, (cy * cy) >> FB);
        sq_sum = add_sat(sq_sum, (cz * cz) >> FB);
      end
      if (!last) return;
      mx = grad_x < 0 ? -grad_x : grad_x;
      my = grad_y < 0 ? -grad_y : grad_y;
      mz = grad_z < 0 ? -grad_z : grad_z;
      s = add_sat(sq_sum, mul_shift_sat(mx, mx));
      s = add_sat(s, mul_shift_sat(my, my));
      s = add_sat(s, mul_shift_sat(mz, mz));
      s = mul_shift_sat(s, {33'd0, inv_rho});
      s = mul_shift_sat(s, {33'd0, inv_rho});
      ratio = ({33'd0, dens} * {33'd0, inv_rho}) >> FB;
      cpos = ratio > ONE_Q;
      cmag = cpos ? ratio - ONE_Q : ONE_Q - ratio;
      den = add_sat(s, ONE_Q);
      qv = (cmag << FB) / den;
      if (cpos) begin
        if (qv > 64'h8000_0000) qv = 64'h8000_0000;
        res.lambda_value = 32'((64'd1 << 32) - qv);
      end else begin
        if (qv > 64'h7FFF_FFFF) qv = 64'h7FFF_FFFF;
        res.lambda_value = qv[31:0];
      end
      res.close_pair = clamped;
      pending.push_back(res);
      grad_x = 0;
      grad_y = 0;
      grad_z = 0;
      sq_sum = 0;
      clamped = 0;
    endfunction

    task check_result(logic [31:0] lam, logic cp);
      lambda_res_t e;
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", lam, 0);
        return;
      end
      e = pending.pop_front();
      if (lam !== e.lambda_value) report_mismatch("lambda_value", lam, e.lambda_value);
      if (cp !== e.close_pair) report_mismatch("close_pair", 32'(cp), 32'(e.close_pair));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0, s_axis_tlast = 0;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [31:0] m_axis_tdata;
  logic cfg_wen_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  lambda_scoreboard sb = new();
  int unsigned send_idle_pct, recv_idle_pct, n_items;
  longint unsigned cycles = 0;

  pbf_lambda_accumulate #(.FRAC_BITS(FB)) i_dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_wen_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_wen_i <= 0;
  endtask

  task automatic send_item(logic [31:0] ox, oy, oz, logic [30:0] dens,
                           logic has_nb, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {33'd0, dens, oz, oy, ox};
    s_axis_tuser <= has_nb;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(ox, oy, oz, dens, has_nb, last);
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(20);
      2: return -$urandom_range(20);
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic random_particle();
    int n;
    logic [30:0] dens;
    n = $urandom_range(6);
    dens = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(131072));
    if (n == 0) begin
      send_item($urandom, $urandom, $urandom, dens, 0, 1);
    end else begin
      for (int k = 0; k < n; k++)
        send_item(rand_offset(), rand_offset(), rand_offset(), dens,
                  $urandom_range(7) != 0, k == n - 1);
    end
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned stop;
    stop = n_items + count;
    while (n_items < stop) random_particle();
  endtask

  initial begin
    n_errors = 0;
    n_items = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    send_item(0, 0, 0, 31'd65536, 1, 1);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 1);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 1);
    send_item(3, -3, 2, 31'd70000, 1, 0);
    send_item(32'd30000, -32'sd20000, 32'd10000, 31'd70000, 1, 0);
    send_item(-32'sd15000, 32'd5000, -32'sd40000, 31'd70000, 1, 1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd40000, 0, 1);
    send_item(32'd70000, 0, 0, 31'd65536, 1, 0);
    send_item(32'd65536, 0, 0, 31'd65536, 1, 1);
    send_item(32'd1000, 32'd2000, 32'd3000, 31'd0, 1, 0);
    send_item(0, 0, 0, 31'd100000, 0, 1);
    drain();

    write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
    write_reg(CFG_COEF, 32'h8000_0000);
    write_reg(CFG_INVRHO, 32'h7FFF_FFFF);
    send_item(32'd1000, -32'sd1000, 32'd5, 31'h7FFF_FFFF, 1, 0);
    send_item(32'h4000_0000, 32'h0, 32'h0, 31'd1, 1, 1);
    send_item(32'd100, 32'd100, 32'd100, 31'd0, 1, 1);
    drain();
    write_reg(CFG_RADIUS, 32'd1);
    write_reg(CFG_COEF, 32'd0);
    write_reg(CFG_INVRHO, 32'd1);
    send_item(0, 0, 1, 31'd12345, 1, 0);
    send_item(32'd1, 0, 0, 31'h7FFF_FFFF, 1, 1);
    drain();

    write_reg(CFG_RADIUS, 32'd65536);
    write_reg(CFG_COEF, -32'sd938734);
    write_reg(CFG_INVRHO, 32'd65536);
    send_idle_pct = 24;
    recv_idle_pct = 62;
    random_phase(280);
    drain();

    write_reg(CFG_RADIUS, 32'd131072);
    write_reg(CFG_COEF, -32'sd200000);
    write_reg(CFG_INVRHO, 32'd600);
    send_idle_pct = 62;
    recv_idle_pct = 24;
    random_phase(280);
    drain();

    write_reg(CFG_RADIUS, 32'($urandom_range(32'h7FFF_FFFF, 1)));
    write_reg(CFG_COEF, 32'(-$signed({1'b0, $urandom_range(32'h7FFF_FFFF)})));
    write_reg(CFG_INVRHO, 32'($urandom_range(32'h7FFF_FFFF, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(280);
    drain();

    $display("Drove %0d items over six register settings; %0d lambda results checked.",
             n_items, sb.n_results);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
